[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL, empty when building for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, clocked on clk, held off during reset
`define SKNG_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("skng assertion failed");
// Next-cycle implication, clocked on clk, held off during reset
`define SKNG_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("skng assertion failed");
`else
`define SKNG_ASSERT_IMP(lbl, ante, cons)
`define SKNG_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[rtl/core/skng_pkg.sv]
// Shared widths, codes, reset values and controller/datapath interface types
package skng_pkg;

	localparam int SAMPLE_BITS  = 16;
	localparam int COEFF_BITS   = 24;
	localparam int ENV_BITS     = 24;
	localparam int GAIN_FRAC    = 16;
	localparam int CFG_BITS     = 24;
	localparam int CFG_IDX_BITS = 2;
	localparam int ABS_BITS     = SAMPLE_BITS + 1;
	localparam int MAG_SHIFT    = ENV_BITS - SAMPLE_BITS;
	localparam int MUL_BITS     = (COEFF_BITS > ENV_BITS) ? COEFF_BITS : ENV_BITS;
	localparam int PROD_BITS    = 2 * MUL_BITS;
	localparam int DIV_CNT_BITS = $clog2(GAIN_FRAC);

	localparam logic [CFG_BITS-1:0] THRESHOLD_RST = CFG_BITS'(47174);
	localparam logic [CFG_BITS-1:0] ATTACK_RST    = CFG_BITS'(16707456);
	localparam logic [CFG_BITS-1:0] RELEASE_RST   = CFG_BITS'(16774886);

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_THRESHOLD = 2'd0,
		REG_ATTACK    = 2'd1,
		REG_RELEASE   = 2'd2
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DIFF, ST_MULT, ST_ENV, ST_CMP, ST_DIV, ST_SQ, ST_GAIN, ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		MUL_ENV, MUL_SQ, MUL_GAIN
	} mul_sel_t;

	typedef struct packed {
		logic     load_in;
		logic     diff_en;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     env_en;
		logic     cmp_en;
		logic     div_step;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic gate;
	} stat_t;

endpackage

[rtl/core/skng_datapath.sv]
// Datapath: envelope smoother, restoring divider, shared multiplier, result register
module skng_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic signed [skng_pkg::SAMPLE_BITS-1:0] sample_in,
	input  logic                                 block_end_in,
	input  logic [skng_pkg::CFG_BITS-1:0]        thr,
	input  logic [skng_pkg::CFG_BITS-1:0]        atk,
	input  logic [skng_pkg::CFG_BITS-1:0]        rel,
	input  skng_pkg::cmd_t                       cmd,
	output skng_pkg::stat_t                      stat,
	output logic signed [skng_pkg::SAMPLE_BITS-1:0] sample_out,
	output logic                                 gating,
	output logic                                 block_end_out
);
	import skng_pkg::*;

	logic [SAMPLE_BITS-1:0] raw_q;
	logic                   neg_q;
	logic [ABS_BITS-1:0]    abs_q;
	logic                   blk_q;
	logic [ENV_BITS-1:0]    env_q;
	logic [ENV_BITS-1:0]    diff_q;
	logic [COEFF_BITS-1:0]  coeff_q;
	logic                   up_q;
	logic [PROD_BITS-1:0]   prod_q;
	logic [ENV_BITS-1:0]    rem_q;
	logic [GAIN_FRAC-1:0]   ratio_q;
	logic                   gating_q;
	logic [SAMPLE_BITS-1:0] sout_q;
	logic                   gout_q;
	logic                   bout_q;

	logic [ABS_BITS-1:0]    abs_in;
	logic [ENV_BITS-1:0]    mag;
	logic                   up;
	logic [ENV_BITS-1:0]    step;
	logic [ENV_BITS-1:0]    env_new;
	logic [MUL_BITS-1:0]    mul_a;
	logic [MUL_BITS-1:0]    mul_b;
	logic [ENV_BITS:0]      rem_sh;
	logic                   rem_ge;
	logic [SAMPLE_BITS-1:0] m;
	logic [SAMPLE_BITS-1:0] gated;

	// magnitude of the incoming sample; the most negative code gives full scale
	assign abs_in = sample_in[SAMPLE_BITS-1] ?
		(ABS_BITS'(0) - {1'b1, sample_in}) : {1'b0, sample_in};
	assign mag = ENV_BITS'(abs_q) << MAG_SHIFT;

	// direction of the envelope move and the truncated step
	assign up      = mag > env_q;
	assign step    = prod_q[COEFF_BITS +: ENV_BITS];
	assign env_new = up_q ? (mag - step) : (mag + step);

	// gate decision on the freshly updated envelope
	assign stat.gate = (thr != '0) && (env_q < thr);

	// one restoring division step: one quotient bit
	assign rem_sh = {rem_q, 1'b0};
	assign rem_ge = rem_sh >= {1'b0, thr};

	// shared multiplier operand selection
	always_comb begin
		case (cmd.mul_sel)
			MUL_ENV: begin
				mul_a = MUL_BITS'(diff_q);
				mul_b = MUL_BITS'(coeff_q);
			end
			MUL_SQ: begin
				mul_a = MUL_BITS'(ratio_q);
				mul_b = MUL_BITS'(ratio_q);
			end
			MUL_GAIN: begin
				mul_a = MUL_BITS'(abs_q);
				mul_b = MUL_BITS'(prod_q[GAIN_FRAC +: GAIN_FRAC]);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// scaled magnitude back to sample, sign restored
	assign m     = prod_q[GAIN_FRAC +: SAMPLE_BITS];
	assign gated = neg_q ? (SAMPLE_BITS'(0) - m) : m;

	// envelope state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			env_q <= '0;
		end else if (cmd.env_en) begin
			env_q <= env_new;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			raw_q <= sample_in;
			neg_q <= sample_in[SAMPLE_BITS-1];
			abs_q <= abs_in;
			blk_q <= block_end_in;
		end
		if (cmd.diff_en) begin
			up_q    <= up;
			diff_q  <= up ? (mag - env_q) : (env_q - mag);
			coeff_q <= up ? COEFF_BITS'(atk) : COEFF_BITS'(rel);
		end
		if (cmd.mul_en) begin
			prod_q <= PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
		end
		if (cmd.cmp_en) begin
			gating_q <= stat.gate;
			rem_q    <= env_q;
		end
		if (cmd.div_step) begin
			rem_q   <= rem_ge ? ENV_BITS'(rem_sh - {1'b0, thr}) : rem_sh[ENV_BITS-1:0];
			ratio_q <= {ratio_q[GAIN_FRAC-2:0], rem_ge};
		end
		if (cmd.out_load) begin
			sout_q <= gating_q ? gated : raw_q;
			gout_q <= gating_q;
			bout_q <= blk_q;
		end
	end

	assign sample_out    = sout_q;
	assign gating        = gout_q;
	assign block_end_out = bout_q;

endmodule

[rtl/core/skng_ctrl.sv]
// Controller: sequences one sample through the datapath and owns the handshakes
module skng_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            sample_valid,
	output logic            sample_ready,
	output logic            result_valid,
	input  logic            result_ready,
	input  skng_pkg::stat_t stat,
	output skng_pkg::cmd_t  cmd
);
	import skng_pkg::*;

	state_t                  state_q;
	state_t                  state_d;
	logic [DIV_CNT_BITS-1:0] cnt_q;
	logic                    out_valid_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.mul_sel  = MUL_ENV;
		sample_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				sample_ready = 1'b1;
				if (sample_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_DIFF;
				end
			end
			ST_DIFF: begin
				cmd.diff_en = 1'b1;
				state_d     = ST_MULT;
			end
			ST_MULT: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_ENV;
				state_d     = ST_ENV;
			end
			ST_ENV: begin
				cmd.env_en = 1'b1;
				state_d    = ST_CMP;
			end
			ST_CMP: begin
				cmd.cmp_en = 1'b1;
				state_d    = stat.gate ? ST_DIV : ST_DONE;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == DIV_CNT_BITS'(GAIN_FRAC - 1)) begin
					state_d = ST_SQ;
				end
			end
			ST_SQ: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_SQ;
				state_d     = ST_GAIN;
			end
			ST_GAIN: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_GAIN;
				state_d     = ST_DONE;
			end
			ST_DONE: begin
				// hand over once the result register is free or being emptied
				if (!out_valid_q || result_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// quotient bit counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.cmp_en) begin
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// result register occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result_valid = out_valid_q;

endmodule

[rtl/core/soft_knee_noise_gate_core.sv]
// Top level of the noise gate: configuration registers, controller and datapath
//
//  channel   signals                              request moves
//  sample    sample_valid / sample_ready          sample_in, block_end_in
//  result    result_valid / result_ready          sample_out, gating, block_end_out
//  config    cfg_en, cfg_index, cfg_data          one register write, no handshake
//
// A sample takes longer from acceptance to result when it is gating than when the gate is
// open; the 16-step restoring divider for envelope/threshold sets the difference.
// One sample is in work at a time; the next can be taken in the cycle after the result moves
// into the output register, which may still be waiting for result_ready.
// Reset is asynchronous and restores the envelope to zero and the registers to defaults.
module soft_knee_noise_gate_core (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    sample_valid,
	output logic                                    sample_ready,
	input  logic signed [skng_pkg::SAMPLE_BITS-1:0] sample_in,
	input  logic                                    block_end_in,
	output logic                                    result_valid,
	input  logic                                    result_ready,
	output logic signed [skng_pkg::SAMPLE_BITS-1:0] sample_out,
	output logic                                    gating,
	output logic                                    block_end_out,
	input  logic                                    cfg_en,
	input  logic [skng_pkg::CFG_IDX_BITS-1:0]       cfg_index,
	input  logic [skng_pkg::CFG_BITS-1:0]           cfg_data
);
	import skng_pkg::*;

	`include "assert_macros.svh"

	logic [CFG_BITS-1:0] thr_q;
	logic [CFG_BITS-1:0] atk_q;
	logic [CFG_BITS-1:0] rel_q;
	cmd_t                cmd;
	stat_t               stat;

	// configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THRESHOLD_RST;
			atk_q <= ATTACK_RST;
			rel_q <= RELEASE_RST;
		end else if (cfg_en) begin
			case (reg_idx_t'(cfg_index))
				REG_THRESHOLD: thr_q <= cfg_data;
				REG_ATTACK:    atk_q <= cfg_data;
				REG_RELEASE:   rel_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	skng_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.stat         (stat),
		.cmd          (cmd)
	);

	skng_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample_in     (sample_in),
		.block_end_in  (block_end_in),
		.thr           (thr_q),
		.atk           (atk_q),
		.rel           (rel_q),
		.cmd           (cmd),
		.stat          (stat),
		.sample_out    (sample_out),
		.gating        (gating),
		.block_end_out (block_end_out)
	);

	// a taken request keeps the input closed while it is worked on
	`SKNG_ASSERT_NXT(a_busy_after_take, sample_valid && sample_ready, !sample_ready)
	// a new result never overwrites one that is still waiting
	`SKNG_ASSERT_IMP(a_no_overwrite, cmd.out_load, !result_valid || result_ready)
	// a zero threshold never gates
	`SKNG_ASSERT_IMP(a_zero_thr_open, result_valid && (thr_q == '0), !gating)
	// the divider only runs for a gated request
	`SKNG_ASSERT_IMP(a_div_when_gated, cmd.div_step, stat.gate)

endmodule

[tb/soft_knee_noise_gate_core_tb.sv]
// Self-checking testbench for the soft-knee noise gate core
module soft_knee_noise_gate_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import skng_pkg::*;

	localparam int CYCLE_LIMIT     = 400000;
	localparam int DIRECTED_ROWS   = 34;
	localparam int RAND_PHASES     = 12;
	localparam int ITEMS_PER_PHASE = 136;
	localparam int DRAIN_CYCLES    = 30;
	localparam int REPORT_CAP      = 200;

	// index that decodes to no register
	localparam logic [CFG_IDX_BITS-1:0] REG_UNMAPPED = 2'd3;

	localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = 16'sh8000;
	localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = 16'sh7FFF;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] smp;
		logic                          gate;
		logic                          bend;
	} gate_res_t;

	typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

	typedef struct {
		row_kind_t               kind;
		logic [CFG_IDX_BITS-1:0] idx;
		logic [CFG_BITS-1:0]     data;
		logic signed [SAMPLE_BITS-1:0] smp;
		logic                    bend;
		logic                    typed;
		gate_res_t               res;
	} stim_row_t;

	logic                          clk          = 1'b0;
	logic                          arst_n       = 1'b0;
	logic                          sample_valid = 1'b0;
	logic                          sample_ready;
	logic signed [SAMPLE_BITS-1:0] sample_in    = '0;
	logic                          block_end_in = 1'b0;
	logic                          result_valid;
	logic                          result_ready = 1'b0;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	logic                          gating;
	logic                          block_end_out;
	logic                          cfg_en       = 1'b0;
	logic [CFG_IDX_BITS-1:0]       cfg_index    = '0;
	logic [CFG_BITS-1:0]           cfg_data     = '0;

	// predictor copy of the block's registers and envelope
	logic [CFG_BITS-1:0] threshold_reg = THRESHOLD_RST;
	logic [CFG_BITS-1:0] attack_reg    = ATTACK_RST;
	logic [CFG_BITS-1:0] release_reg   = RELEASE_RST;
	logic [ENV_BITS-1:0] env_track     = '0;

	gate_res_t   pending_results[$];
	stim_row_t   directed_rows[DIRECTED_ROWS];
	logic        send_calm     = 1'b0;
	int unsigned cycle_count   = 0;
	int          mismatches    = 0;
	int          samples_sent  = 0;
	int          reg_writes    = 0;
	int          gated_results = 0;

	soft_knee_noise_gate_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample_valid  (sample_valid),
		.sample_ready  (sample_ready),
		.sample_in     (sample_in),
		.block_end_in  (block_end_in),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.sample_out    (sample_out),
		.gating        (gating),
		.block_end_out (block_end_out),
		.cfg_en        (cfg_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #10 clk = ~clk;

	// run watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout at %0t with %0d results outstanding", $time,
				pending_results.size());
			$display("Mismatches found");
			$finish;
		end
	end

	// envelope follower and gain stage; updates the tracked envelope
	function automatic gate_res_t gate_predict(input logic signed [SAMPLE_BITS-1:0] s,
			input logic b);
		logic [63:0] raw, absval, mag, env, coeff, ratio, gain, scaled, neg_scaled;
		gate_res_t   r;
		raw    = {48'd0, s};
		absval = s[SAMPLE_BITS-1] ? (64'd1 << SAMPLE_BITS) - raw : raw;
		mag    = absval << MAG_SHIFT;
		env    = {40'd0, env_track};
		coeff  = (mag > env) ? {40'd0, attack_reg} : {40'd0, release_reg};
		// step towards the magnitude, truncated so it never overshoots
		if (env >= mag)
			env = mag + (((env - mag) * coeff) >> COEFF_BITS);
		else
			env = mag - (((mag - env) * coeff) >> COEFF_BITS);
		env_track = env[ENV_BITS-1:0];
		r.smp  = s;
		r.gate = 1'b0;
		r.bend = b;
		// below threshold: gain is the squared ratio, zero threshold never gates
		if (threshold_reg != '0 && env_track < threshold_reg) begin
			ratio      = ({40'd0, env_track} << GAIN_FRAC) / {40'd0, threshold_reg};
			gain       = (ratio * ratio) >> GAIN_FRAC;
			scaled     = (absval * gain) >> GAIN_FRAC;
			neg_scaled = 64'd0 - scaled;
			r.smp  = s[SAMPLE_BITS-1] ? neg_scaled[SAMPLE_BITS-1:0] : scaled[SAMPLE_BITS-1:0];
			r.gate = 1'b1;
		end
		return r;
	endfunction

	function automatic logic [CFG_BITS-1:0] pick_coeff();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return 24'hFFFFFF;
			2, 3: return 24'hFFFFFF - 24'($urandom_range(0, 24'h7FFFF));
			4: return 24'($urandom);
			default: return 24'($urandom_range(0, 24'hFFFF));
		endcase
	endfunction

	function automatic stim_row_t reg_row(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_BITS-1:0] data);
		stim_row_t r;
		r       = '{ROW_WRITE, idx, data, '0, 1'b0, 1'b0, '0};
		return r;
	endfunction

	function automatic stim_row_t smp_row(input logic signed [SAMPLE_BITS-1:0] s,
			input logic b);
		stim_row_t r;
		r       = '{ROW_SAMPLE, '0, '0, s, b, 1'b0, '0};
		return r;
	endfunction

	function automatic stim_row_t typed_row(input logic signed [SAMPLE_BITS-1:0] s,
			input logic b, input logic signed [SAMPLE_BITS-1:0] out_smp, input logic gate);
		stim_row_t r;
		r       = '{ROW_SAMPLE, '0, '0, s, b, 1'b1, '0};
		r.res   = '{out_smp, gate, b};
		return r;
	endfunction

	// let every outstanding request come back before touching the registers
	task automatic drain_results();
		sample_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_BITS-1:0] data);
		if (!cfg_en)
			drain_results();
		cfg_en    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			REG_THRESHOLD: threshold_reg = data;
			REG_ATTACK:    attack_reg    = data;
			REG_RELEASE:   release_reg   = data;
			default: ;
		endcase
		reg_writes++;
	endtask

	// one sample request; valid is held over when no gap is drawn
	task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic b,
			input logic typed, input gate_res_t typed_res);
		int        gap;
		gate_res_t pred;
		gap = send_calm ? 0 : $urandom_range(0, 4);
		if (cfg_en)
			cfg_en <= 1'b0;
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample_in    <= s;
		block_end_in <= b;
		do @(posedge clk); while (!sample_ready);
		pred = gate_predict(s, b);
		pending_results.push_back(typed ? typed_res : pred);
		samples_sent++;
	endtask

	// result side: random back-pressure, compare against oldest expectation
	initial begin : result_sink
		gate_res_t want, got;
		int        stall, calm_left;
		logic      calm;
		calm      = 1'b0;
		calm_left = 0;
		@(posedge arst_n);
		forever begin
			if (calm_left == 0) begin
				calm_left = $urandom_range(16, 64);
				calm      = ($urandom_range(0, 3) == 0);
			end
			calm_left--;
			stall = calm ? 0 : $urandom_range(0, 4);
			if (stall > 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!result_valid);
			got = '{sample_out, gating, block_end_out};
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_CAP)
					$display("%0t: unexpected result, expected none, got %0d %0b %0b",
						$time, got.smp, got.gate, got.bend);
			end else begin
				want = pending_results.pop_front();
				if (got.gate === 1'b1)
					gated_results++;
				if (got !== want) begin
					mismatches++;
					if (mismatches <= REPORT_CAP)
						$display({"%0t: expected sample_out %0d gating %0b block_end %0b,",
							" got %0d %0b %0b"}, $time, want.smp, want.gate, want.bend,
							got.smp, got.gate, got.bend);
				end
			end
		end
	end

	// stimulus
	initial begin
		logic signed [SAMPLE_BITS-1:0] smp;
		logic [CFG_BITS-1:0]           thr;
		int                            mode, span, sent, amp, v, k;

		directed_rows = '{
			typed_row(16'sd0, 1'b0, 16'sd0, 1'b1),          // closed gate straight after reset
			smp_row(SMP_MAX, 1'b1),
			smp_row(SMP_MIN, 1'b0),
			smp_row(-16'sd1, 1'b0),
			smp_row(16'sd1, 1'b0),
			reg_row(REG_ATTACK, 24'd0),                     // envelope follows magnitude exactly
			reg_row(REG_RELEASE, 24'd0),
			typed_row(SMP_MAX, 1'b0, SMP_MAX, 1'b0),
			typed_row(SMP_MIN, 1'b1, SMP_MIN, 1'b0),
			typed_row(16'sd0, 1'b0, 16'sd0, 1'b1),
			reg_row(REG_THRESHOLD, 24'd0),                  // zero threshold never gates
			typed_row(16'sd0, 1'b0, 16'sd0, 1'b0),
			typed_row(-16'sd5, 1'b1, -16'sd5, 1'b0),
			reg_row(REG_THRESHOLD, 24'hFFFFFF),             // threshold above unity
			smp_row(SMP_MIN, 1'b0),
			smp_row(SMP_MAX, 1'b0),
			smp_row(16'sd100, 1'b0),
			reg_row(REG_UNMAPPED, 24'd0),                   // write to nowhere, must be dropped
			smp_row(SMP_MAX, 1'b1),
			reg_row(REG_ATTACK, 24'hFFFFFF),
			reg_row(REG_RELEASE, 24'hFFFFFF),
			reg_row(REG_THRESHOLD, 24'h800000),
			smp_row(SMP_MIN, 1'b0),
			smp_row(SMP_MAX, 1'b0),
			smp_row(16'sd0, 1'b0),
			smp_row(-16'sd1, 1'b0),
			reg_row(REG_THRESHOLD, 24'd1),
			smp_row(16'sd0, 1'b0),
			smp_row(16'sd1, 1'b1),
			reg_row(REG_THRESHOLD, THRESHOLD_RST),
			reg_row(REG_ATTACK, ATTACK_RST),
			reg_row(REG_RELEASE, RELEASE_RST),
			smp_row(SMP_MIN, 1'b0),
			smp_row(16'sd12345, 1'b0)
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed table
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WRITE)
				write_reg(directed_rows[i].idx, directed_rows[i].data);
			else
				send_sample(directed_rows[i].smp, directed_rows[i].bend,
					directed_rows[i].typed, directed_rows[i].res);
		end

		// random phases, each under a fresh register setting
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			if ($urandom_range(0, 2) == 0)
				write_reg(REG_UNMAPPED, 24'($urandom));
			case ($urandom_range(0, 7))
				0: thr = '0;
				1: thr = 24'd1;
				2: thr = 24'h800000;
				3: thr = 24'hFFFFFF;
				4: thr = THRESHOLD_RST;
				5, 6: thr = 24'($urandom_range(1, 24'h200000));
				default: thr = 24'($urandom);
			endcase
			write_reg(REG_THRESHOLD, thr);
			write_reg(REG_ATTACK, pick_coeff());
			write_reg(REG_RELEASE, pick_coeff());
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				mode      = $urandom_range(0, 9);
				span      = $urandom_range(1, 24);
				send_calm = ($urandom_range(0, 3) == 0);
				for (k = 0; k < span && sent < ITEMS_PER_PHASE; k++) begin
					// bursts of noise, quiet passages, loud passages and silence
					case (mode)
						0, 1: v = $urandom;
						2, 3, 4: begin
							amp = 1 << $urandom_range(0, 11);
							v   = $urandom_range(0, 2 * amp) - amp;
						end
						5, 6: begin
							v = 32767 - $urandom_range(0, 4095);
							if ($urandom_range(0, 1) == 1)
								v = -v - 1;
						end
						7: case ($urandom_range(0, 4))
							0: v = -32768;
							1: v = 32767;
							2: v = 0;
							3: v = -1;
							default: v = 1;
						endcase
						default: v = 0;
					endcase
					smp = v[SAMPLE_BITS-1:0];
					send_sample(smp, ($urandom_range(0, 7) == 0), 1'b0, '0);
					sent++;
				end
			end
		end

		// wind down and allow stray results to show up
		send_calm = 1'b0;
		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d samples through %0d register writes; %0d results came back gated.",
			samples_sent, reg_writes, gated_results);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
